// ----- design/rfm_pkg.sv -----
`timescale 1ns / 1ps
// rfm_pkg: shared types, widths and constants of the reciprocal frequency meter.
// No dependencies; every other file of the meter refers to it by scoped names.
package rfm_pkg;

	// Field and register widths
	localparam int REF_W             = 27;
	localparam int AVG_W             = 8;
	localparam int SUM_W             = 40;
	localparam int FREQ_OUT_W        = 20;
	localparam int OUT_DIGITS        = 6;
	localparam int OUT_BCD_W         = 4 * OUT_DIGITS;
	localparam int COUNTER_WIDTH_DEF = 32;

	// Decimal width of the clamp
	localparam int DIGITS = 6;
	localparam int BCD_W  = 4 * DIGITS;

	// Register reset values
	localparam logic [REF_W-1:0] REF_CLOCK_RESET = 27'd8000000;
	localparam logic [AVG_W-1:0] AVG_COUNT_RESET = 8'd10;

	// Configuration register map (index is paddr[2])
	localparam int  ADDR_W        = 3;
	localparam logic REG_REF_CLOCK = 1'b0;
	localparam logic REG_AVG_COUNT = 1'b1;

	// 10^n - 1, evaluated at elaboration
	function automatic logic [SUM_W-1:0] pow10_minus1(input int n);
		logic [SUM_W-1:0] p;
		p = SUM_W'(1);
		for (int i = 0; i < n; i++) begin
			p = SUM_W'(p * SUM_W'(10));
		end
		return p - SUM_W'(1);
	endfunction

	localparam logic [SUM_W-1:0] CLAMP_LIMIT = pow10_minus1(DIGITS);
	localparam int               CLAMP_W     = $clog2(CLAMP_LIMIT + SUM_W'(1));

	// Result item
	typedef struct packed {
		logic [FREQ_OUT_W-1:0] avg_freq_hz;
		logic [3:0]            digit_hundred_thousands;
		logic [3:0]            digit_ten_thousands;
		logic [3:0]            digit_thousands;
		logic [3:0]            digit_hundreds;
		logic [3:0]            digit_tens;
		logic [3:0]            digit_ones;
		logic                  overrange;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic tick;        // tick transfer this cycle
		logic start_freq;  // closing edge: start ref/period divide
		logic accum;       // add the quotient into the sum
		logic start_mean;  // start sum/n divide, clear sum and count
		logic bcd_start;   // clamp the mean, start decimal conversion
		logic out_load;    // load the result register
	} rfm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic close;       // current tick edge ends a period
		logic avg_due;     // the period being added completes an average
		logic div_done;
		logic bcd_done;
		logic out_full;
	} rfm_stat_t;

endpackage

// ----- design/rfm_if.sv -----
`timescale 1ns / 1ps
// rfm_tick_if / rfm_result_if: valid/ready channels of the frequency meter.
// Depends on rfm_pkg for field widths.
interface rfm_tick_if;
	logic valid;
	logic ready;
	logic edge_seen;

	modport source (output valid, output edge_seen, input ready);
	modport sink   (input valid, input edge_seen, output ready);
endinterface

interface rfm_result_if;
	logic                            valid;
	logic                            ready;
	logic [rfm_pkg::FREQ_OUT_W-1:0]  avg_freq_hz;
	logic [3:0]                      digit_hundred_thousands;
	logic [3:0]                      digit_ten_thousands;
	logic [3:0]                      digit_thousands;
	logic [3:0]                      digit_hundreds;
	logic [3:0]                      digit_tens;
	logic [3:0]                      digit_ones;
	logic                            overrange;

	modport source (
		output valid, output avg_freq_hz, output digit_hundred_thousands,
		output digit_ten_thousands, output digit_thousands, output digit_hundreds,
		output digit_tens, output digit_ones, output overrange, input ready
	);
	modport sink (
		input valid, input avg_freq_hz, input digit_hundred_thousands,
		input digit_ten_thousands, input digit_thousands, input digit_hundreds,
		input digit_tens, input digit_ones, input overrange, output ready
	);
endinterface

// ----- design/reciprocal_frequency_meter_unit.sv -----
`timescale 1ns / 1ps
// reciprocal_frequency_meter_unit: top level with the APB register file.
// Depends on rfm_pkg, rfm_if, rfm_ctrl and rfm_datapath.
//
//   channel   dir   handshake        payload
//   tick      in    valid / ready    edge_seen
//   result    out   valid / ready    avg_freq_hz, six digits, overrange
//   apb       in    psel / penable   ref_clock_hz (0x0), avg_count (0x4)
//
// A tick without a closing edge leaves the meter ready for the next tick. A tick
// with a closing edge holds off ticks for the period divide (one bit per cycle in
// the shared divider). A completed average adds a second divide and the decimal
// conversion. A finished average that finds the previous result not yet taken
// holds off ticks until that result is taken.
// Reset is asynchronous and needs no clearing pass.
module reciprocal_frequency_meter_unit #(
	parameter int COUNTER_WIDTH = rfm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rfm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	rfm_tick_if.sink                   tick,
	rfm_result_if.source               result
);
	logic [rfm_pkg::REF_W-1:0] ref_clock_hz_q;
	logic [rfm_pkg::AVG_W-1:0] avg_count_q;
	logic                      reg_wr;
	rfm_pkg::rfm_cmd_t         cmd;
	rfm_pkg::rfm_stat_t        stat;
	rfm_pkg::out_item_t        out_item;

	// configuration registers
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clock_hz_q <= rfm_pkg::REF_CLOCK_RESET;
			avg_count_q    <= rfm_pkg::AVG_COUNT_RESET;
		end else if (reg_wr) begin
			case (paddr[2])
				rfm_pkg::REG_REF_CLOCK: ref_clock_hz_q <= pwdata[rfm_pkg::REF_W-1:0];
				rfm_pkg::REG_AVG_COUNT: avg_count_q    <= pwdata[rfm_pkg::AVG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rfm_pkg::REG_REF_CLOCK: prdata = 32'(ref_clock_hz_q);
			rfm_pkg::REG_AVG_COUNT: prdata = 32'(avg_count_q);
			default:                prdata = '0;
		endcase
	end

	rfm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rfm_datapath #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.edge_seen    (tick.edge_seen),
		.ref_clock_hz (ref_clock_hz_q),
		.avg_count    (avg_count_q),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_item     (out_item)
	);

	// result channel fields
	assign result.avg_freq_hz             = out_item.avg_freq_hz;
	assign result.digit_hundred_thousands = out_item.digit_hundred_thousands;
	assign result.digit_ten_thousands     = out_item.digit_ten_thousands;
	assign result.digit_thousands         = out_item.digit_thousands;
	assign result.digit_hundreds          = out_item.digit_hundreds;
	assign result.digit_tens              = out_item.digit_tens;
	assign result.digit_ones              = out_item.digit_ones;
	assign result.overrange               = out_item.overrange;

`ifndef SYNTH
	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !result.valid)
		else $error("result register loaded while full");

	// ticks stop while the period divide runs
	a_hold_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_freq |=> !tick.ready)
		else $error("tick taken during divide");

	// decimal conversion yields valid digits
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.digit_ones <= 4'd9) && (result.digit_tens <= 4'd9)
		&& (result.digit_hundred_thousands <= 4'd9))
		else $error("digit out of range");
`endif

endmodule

// ----- design/rfm_div.sv -----
`timescale 1ns / 1ps
// rfm_div: restoring divider, one quotient bit per cycle.
// Depends on rfm_pkg.
module rfm_div #(
	parameter int DVS_W = rfm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rfm_pkg::SUM_W-1:0] dividend,
	input  logic [DVS_W-1:0]          divisor,
	output logic                      done,
	output logic [rfm_pkg::SUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(rfm_pkg::SUM_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [rfm_pkg::SUM_W-1:0] dvd_q;
	logic [DVS_W-1:0]          rem_q;
	logic [DVS_W-1:0]          dvs_q;
	logic [DVS_W:0]            trial;

	// trial subtract of the shifted partial remainder; top bit is the borrow
	assign trial = {rem_q, dvd_q[rfm_pkg::SUM_W-1]} - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(rfm_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands: quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[rfm_pkg::SUM_W-2:0], ~trial[DVS_W]};
			rem_q <= trial[DVS_W] ? {rem_q[DVS_W-2:0], dvd_q[rfm_pkg::SUM_W-1]}
			                      : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- design/rfm_bcd.sv -----
`timescale 1ns / 1ps
// rfm_bcd: shift-and-add-3 binary to decimal conversion, one bit per cycle.
// Depends on rfm_pkg (CLAMP_W, DIGITS).
module rfm_bcd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rfm_pkg::CLAMP_W-1:0] value,
	output logic                        done,
	output logic [rfm_pkg::BCD_W-1:0]   digits
);
	localparam int CNT_W = (rfm_pkg::CLAMP_W > 1) ? $clog2(rfm_pkg::CLAMP_W) : 1;

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [rfm_pkg::CLAMP_W-1:0] val_q;
	logic [rfm_pkg::BCD_W-1:0]   bcd_q;
	logic [rfm_pkg::BCD_W-1:0]   adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int k = 0; k < rfm_pkg::DIGITS; k++) begin
			adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
			                                          : bcd_q[4*k +: 4];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(rfm_pkg::CLAMP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift register
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[rfm_pkg::BCD_W-2:0], val_q[rfm_pkg::CLAMP_W-1]};
			val_q <= val_q << 1;
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

// ----- design/rfm_ctrl.sv -----
`timescale 1ns / 1ps
// rfm_ctrl: sequencer of the frequency meter; issues commands to rfm_datapath.
// Depends on rfm_pkg (rfm_cmd_t, rfm_stat_t).
module rfm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick_valid,
	output logic               tick_ready,
	input  rfm_pkg::rfm_stat_t stat,
	output rfm_pkg::rfm_cmd_t  cmd
);
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DIV_FREQ = 3'd1;
	localparam logic [2:0] ST_DIV_MEAN = 3'd2;
	localparam logic [2:0] ST_BCD      = 3'd3;
	localparam logic [2:0] ST_OUT      = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign tick_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.tick = tick_valid;
				if (tick_valid && stat.close) begin
					cmd.start_freq = 1'b1;
					state_d        = ST_DIV_FREQ;
				end
			end
			ST_DIV_FREQ: begin
				if (stat.div_done) begin
					cmd.accum = 1'b1;
					if (stat.avg_due) begin
						cmd.start_mean = 1'b1;
						state_d        = ST_DIV_MEAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DIV_MEAN: begin
				if (stat.div_done) begin
					cmd.bcd_start = 1'b1;
					state_d       = ST_BCD;
				end
			end
			ST_BCD: begin
				if (stat.bcd_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// previous result still waiting: hold
				if (!stat.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/rfm_datapath.sv -----
`timescale 1ns / 1ps
// rfm_datapath: tick counter, period stamp, frequency sum, clamp and result register.
// Depends on rfm_pkg, rfm_div and rfm_bcd.
module rfm_datapath #(
	parameter int COUNTER_WIDTH = rfm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rfm_pkg::rfm_cmd_t         cmd,
	output rfm_pkg::rfm_stat_t        stat,
	input  logic                      edge_seen,
	input  logic [rfm_pkg::REF_W-1:0] ref_clock_hz,
	input  logic [rfm_pkg::AVG_W-1:0] avg_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rfm_pkg::out_item_t        out_item
);
	logic [COUNTER_WIDTH-1:0]      tick_count_q;
	logic [COUNTER_WIDTH-1:0]      start_stamp_q;
	logic                          measuring_q;
	logic [rfm_pkg::AVG_W-1:0]     periods_done_q;
	logic [rfm_pkg::SUM_W-1:0]     freq_sum_q;

	logic [COUNTER_WIDTH-1:0]      diff;
	logic [COUNTER_WIDTH-1:0]      period;
	logic [rfm_pkg::AVG_W-1:0]     n_eff;
	logic [rfm_pkg::AVG_W-1:0]     pd_next;
	logic [rfm_pkg::SUM_W-1:0]     sum_next;

	logic                          div_start;
	logic [rfm_pkg::SUM_W-1:0]     div_dividend;
	logic [COUNTER_WIDTH-1:0]      div_divisor;
	logic                          div_done;
	logic [rfm_pkg::SUM_W-1:0]     quotient;

	logic                          over;
	logic [rfm_pkg::CLAMP_W-1:0]   clamped;
	logic                          over_q;
	logic [rfm_pkg::CLAMP_W-1:0]   clamped_q;
	logic                          bcd_done;
	logic [rfm_pkg::BCD_W-1:0]     bcd_digits;
	logic [rfm_pkg::OUT_BCD_W-1:0] dig6;

	logic                          out_valid_q;
	rfm_pkg::out_item_t            out_q;

	// period in ticks, zero taken as one
	assign diff   = tick_count_q - start_stamp_q;
	assign period = (diff == '0) ? COUNTER_WIDTH'(1) : diff;

	// average bookkeeping; a count of zero acts as one
	assign n_eff    = (avg_count == '0) ? rfm_pkg::AVG_W'(1) : avg_count;
	assign pd_next  = periods_done_q + 1'b1;
	assign sum_next = freq_sum_q + quotient;

	assign stat.close    = edge_seen && measuring_q;
	assign stat.avg_due  = (pd_next >= n_eff) || (pd_next == '0);
	assign stat.div_done = div_done;
	assign stat.bcd_done = bcd_done;
	assign stat.out_full = out_valid_q;

	// shared divider: ref/period, then sum/n
	assign div_start    = cmd.start_freq || cmd.start_mean;
	assign div_dividend = cmd.start_mean ? sum_next : rfm_pkg::SUM_W'(ref_clock_hz);
	assign div_divisor  = cmd.start_mean ? COUNTER_WIDTH'(n_eff) : period;

	rfm_div #(
		.DVS_W (COUNTER_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// clamp of the mean
	assign over    = (quotient > rfm_pkg::CLAMP_LIMIT);
	assign clamped = over ? rfm_pkg::CLAMP_W'(rfm_pkg::CLAMP_LIMIT)
	                      : rfm_pkg::CLAMP_W'(quotient);

	rfm_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.bcd_start),
		.value  (clamped),
		.done   (bcd_done),
		.digits (bcd_digits)
	);

	// tick counter, stamp and averaging state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= '0;
			start_stamp_q  <= '0;
			measuring_q    <= 1'b0;
			periods_done_q <= '0;
			freq_sum_q     <= '0;
		end else begin
			if (cmd.tick) begin
				if (stat.close) begin
					tick_count_q <= '0;
					measuring_q  <= 1'b0;
				end else begin
					if (tick_count_q != '1) begin
						tick_count_q <= tick_count_q + 1'b1;
					end
					if (edge_seen) begin
						start_stamp_q <= tick_count_q;
						measuring_q   <= 1'b1;
					end
				end
			end
			if (cmd.accum) begin
				if (cmd.start_mean) begin
					freq_sum_q     <= '0;
					periods_done_q <= '0;
				end else begin
					freq_sum_q     <= sum_next;
					periods_done_q <= pd_next;
				end
			end
		end
	end

	// clamped mean held for the result
	always_ff @(posedge clk) begin
		if (cmd.bcd_start) begin
			over_q    <= over;
			clamped_q <= clamped;
		end
	end

	// lowest six decimal places
	assign dig6 = rfm_pkg::OUT_BCD_W'(bcd_digits);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.avg_freq_hz             <= rfm_pkg::FREQ_OUT_W'(clamped_q);
			out_q.digit_hundred_thousands <= dig6[23:20];
			out_q.digit_ten_thousands     <= dig6[19:16];
			out_q.digit_thousands         <= dig6[15:12];
			out_q.digit_hundreds          <= dig6[11:8];
			out_q.digit_tens              <= dig6[7:4];
			out_q.digit_ones              <= dig6[3:0];
			out_q.overrange               <= over_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
